@@ src/fexp_pkg.sv @@
// Package for the single-precision exponential pipeline: constants, the per-beat
// context record and the unpack, align, normalize and round helpers.
// No dependencies; used by fexp_fma and fp32_exp_poly5_top.
package fexp_pkg;

  // Signed exponent wide enough for every intermediate lsb exponent.
  typedef logic signed [11:0] exp_t;

  localparam exp_t EXP_MIN_Q = -12'sd149;
  localparam exp_t EXP_BIAS  = 12'sd150;
  localparam exp_t EXP_INF   = 12'sd255;
  localparam exp_t SUM_SPAN  = 12'sd62;

  // Stage counts, used to size the context delay lines.
  localparam int FMA_LAT = 6;

  // Polynomial and reduction constants.
  localparam logic [31:0] K_L2E     = 32'h3FB8AA3B;
  localparam logic [31:0] K_NLN2_HI = 32'hBF317218;
  localparam logic [31:0] K_NLN2_LO = 32'h3102E308;
  localparam logic [31:0] K_ONE     = 32'h3F800000;
  localparam logic [31:0] K_P2      = 32'h3EFFFEFE;
  localparam logic [31:0] K_P3      = 32'h3E2AABD6;
  localparam logic [31:0] K_P4      = 32'h3D2B9509;
  localparam logic [31:0] K_P5      = 32'h3C0831F1;
  localparam logic [31:0] NEG_ZERO  = 32'h80000000;
  localparam logic [31:0] POS_ZERO  = 32'h00000000;
  localparam logic [31:0] POS_INF   = 32'h7F800000;
  localparam logic [31:0] QUIET_BIT = 32'h00400000;
  localparam logic [30:0] INF_MAG   = 31'h7F800000;
  localparam logic [30:0] LIMIT_MAG = 31'h43800000;

  // Side information that travels with each beat through the whole pipeline.
  typedef struct packed {
    logic               special;
    logic [31:0]        spec_y;
    logic [31:0]        x;
    logic [31:0]        k;
    logic signed [10:0] kint;
    logic [31:0]        r;
  } ctx_t;

  // Unpacked finite operand: value = m * 2^e.
  typedef struct packed {
    logic        sg;
    logic [23:0] m;
    exp_t        e;
  } unp_t;

  // Shifted significand with round information, ready for the final round.
  typedef struct packed {
    logic        sg;
    logic [23:0] m;
    logic        guard;
    logic        sticky;
    exp_t        q;
  } rnd_t;

  function automatic unp_t unpack(input logic [31:0] b);
    unp_t u;
    u.sg = b[31];
    if (b[30:23] == 8'd0) begin
      u.m = {1'b0, b[22:0]};
      u.e = EXP_MIN_Q;
    end else begin
      u.m = {1'b1, b[22:0]};
      u.e = exp_t'({4'b0, b[30:23]}) - EXP_BIAS;
    end
    return u;
  endfunction

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // Bring m * 2^e to lsb exponent lo (sh = e - lo), jamming lost bits into the lsb.
  function automatic logic [63:0] align_to(input logic [63:0] m, input exp_t sh);
    logic [127:0] big;
    exp_t         d;
    if (sh >= 0) return m << sh[5:0];
    d = -sh;
    if (d >= 12'sd64) return {63'b0, |m};
    big = {m, 64'b0} >> d[6:0];
    return big[127:64] | {63'b0, |big[63:0]};
  endfunction

  // Lsb exponent of the rounded result, clamped to the subnormal floor.
  function automatic exp_t norm_exp(input logic [63:0] mag, input exp_t ex);
    exp_t q;
    q = ex + exp_t'({5'b0, bit_len64(mag)}) - 12'sd24;
    if (q < EXP_MIN_Q) q = EXP_MIN_Q;
    return q;
  endfunction

  // Shift the magnitude to lsb exponent q and collect guard and sticky bits.
  function automatic rnd_t shift_to(input logic sg, input logic [63:0] mag,
                                    input exp_t ex, input exp_t q);
    rnd_t         r;
    exp_t         d;
    logic [4:0]   sl;
    logic [6:0]   dd;
    logic [127:0] big;
    r.sg = sg;
    r.q  = q;
    d    = q - ex;
    if (d < 0) begin
      sl       = 5'(-d);
      r.m      = 24'(mag << sl);
      r.guard  = 1'b0;
      r.sticky = 1'b0;
    end else begin
      dd       = (d > 12'sd64) ? 7'd64 : d[6:0];
      big      = {mag, 64'b0} >> dd;
      r.m      = big[87:64];
      r.guard  = big[63];
      r.sticky = |big[62:0];
    end
    return r;
  endfunction

  // Round to nearest even and pack, with overflow to infinity.
  function automatic logic [31:0] round_pack(input rnd_t r);
    logic [24:0] m;
    exp_t        q;
    exp_t        be;
    m = {1'b0, r.m} + {24'b0, r.guard & (r.sticky | r.m[0])};
    q = r.q;
    if (m[24]) begin
      m = 25'h0800000;
      q = q + 12'sd1;
    end
    if (m[23]) begin
      be = q + EXP_BIAS;
      if (be >= EXP_INF) return {r.sg, POS_INF[30:0]};
      return {r.sg, be[7:0], m[22:0]};
    end
    return {r.sg, 8'd0, m[22:0]};
  endfunction

endpackage

@@ src/fexp_fma.sv @@
// Six-stage fused multiply-add for finite binary32 operands, rounded once to
// nearest even with subnormals kept. Depends on fexp_pkg.
module fexp_fma (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            in_vld,
  input  fexp_pkg::ctx_t  in_ctx,
  input  logic [31:0]     a_bits,
  input  logic [31:0]     b_bits,
  input  logic [31:0]     c_bits,
  output logic            out_vld,
  output fexp_pkg::ctx_t  out_ctx,
  output logic [31:0]     y_bits
);

  logic [fexp_pkg::FMA_LAT-1:0] vld_r;
  fexp_pkg::ctx_t               ctx_r [fexp_pkg::FMA_LAT];

  // Valid bits and side context move together with the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[fexp_pkg::FMA_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_r[0] <= in_ctx;
      for (int i = 1; i < fexp_pkg::FMA_LAT; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  // Stage 1: unpack and multiply the significands.
  fexp_pkg::unp_t ua, ub, uc;
  logic           s1_sp_r, s1_sc_r;
  logic [47:0]    s1_mp_r;
  logic [23:0]    s1_mc_r;
  fexp_pkg::exp_t s1_ep_r, s1_ec_r;
  logic [31:0]    s1_c_r;

  always_comb begin
    ua = fexp_pkg::unpack(a_bits);
    ub = fexp_pkg::unpack(b_bits);
    uc = fexp_pkg::unpack(c_bits);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_sp_r <= ua.sg ^ ub.sg;
      s1_mp_r <= ua.m * ub.m;
      s1_ep_r <= ua.e + ub.e;
      s1_sc_r <= uc.sg;
      s1_mc_r <= uc.m;
      s1_ec_r <= uc.e;
      s1_c_r  <= c_bits;
    end
  end

  // Stage 2: zero cases and alignment of both terms to a common lsb.
  logic           s2_byp_nxt, s2_byp_r;
  logic [31:0]    s2_byp_y_nxt, s2_byp_y_r;
  logic [63:0]    s2_tp_nxt, s2_tc_nxt, s2_tp_r, s2_tc_r;
  fexp_pkg::exp_t s2_lo_nxt, s2_lo_r;
  logic           s2_sp_r, s2_sc_r;
  fexp_pkg::exp_t top_p, top_c, hi;

  always_comb begin
    top_p        = s1_ep_r + fexp_pkg::exp_t'({5'b0, fexp_pkg::bit_len64({16'b0, s1_mp_r})});
    top_c        = s1_ec_r + fexp_pkg::exp_t'({5'b0, fexp_pkg::bit_len64({40'b0, s1_mc_r})});
    hi           = (top_p > top_c) ? top_p : top_c;
    s2_byp_nxt   = 1'b0;
    s2_byp_y_nxt = fexp_pkg::POS_ZERO;
    s2_tp_nxt    = {16'b0, s1_mp_r};
    s2_tc_nxt    = '0;
    s2_lo_nxt    = s1_ep_r;
    if (s1_mp_r == 48'd0) begin
      s2_byp_nxt = 1'b1;
      if (s1_mc_r == 24'd0) begin
        s2_byp_y_nxt = (s1_sp_r && s1_sc_r) ? fexp_pkg::NEG_ZERO : fexp_pkg::POS_ZERO;
      end else begin
        s2_byp_y_nxt = s1_c_r;
      end
    end else if (s1_mc_r != 24'd0) begin
      s2_lo_nxt = hi - fexp_pkg::SUM_SPAN;
      s2_tp_nxt = fexp_pkg::align_to({16'b0, s1_mp_r}, s1_ep_r - s2_lo_nxt);
      s2_tc_nxt = fexp_pkg::align_to({40'b0, s1_mc_r}, s1_ec_r - s2_lo_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_byp_r   <= s2_byp_nxt;
      s2_byp_y_r <= s2_byp_y_nxt;
      s2_tp_r    <= s2_tp_nxt;
      s2_tc_r    <= s2_tc_nxt;
      s2_lo_r    <= s2_lo_nxt;
      s2_sp_r    <= s1_sp_r;
      s2_sc_r    <= s1_sc_r;
    end
  end

  // Stage 3: signed add; an exact cancellation gives positive zero.
  logic           s3_byp_nxt, s3_byp_r;
  logic [31:0]    s3_byp_y_nxt, s3_byp_y_r;
  logic [63:0]    s3_mag_nxt, s3_mag_r;
  logic           s3_sg_nxt, s3_sg_r;
  fexp_pkg::exp_t s3_ex_r;

  always_comb begin
    s3_byp_nxt   = s2_byp_r;
    s3_byp_y_nxt = s2_byp_y_r;
    s3_sg_nxt    = s2_sp_r;
    s3_mag_nxt   = s2_tp_r + s2_tc_r;
    if (s2_sp_r != s2_sc_r) begin
      if (s2_tp_r > s2_tc_r) begin
        s3_mag_nxt = s2_tp_r - s2_tc_r;
      end else if (s2_tc_r > s2_tp_r) begin
        s3_mag_nxt = s2_tc_r - s2_tp_r;
        s3_sg_nxt  = s2_sc_r;
      end else begin
        s3_mag_nxt = '0;
        if (!s2_byp_r) begin
          s3_byp_nxt   = 1'b1;
          s3_byp_y_nxt = fexp_pkg::POS_ZERO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_byp_r   <= s3_byp_nxt;
      s3_byp_y_r <= s3_byp_y_nxt;
      s3_mag_r   <= s3_mag_nxt;
      s3_sg_r    <= s3_sg_nxt;
      s3_ex_r    <= s2_lo_r;
    end
  end

  // Stage 4: result lsb exponent from the leading one.
  logic           s4_byp_r, s4_sg_r;
  logic [31:0]    s4_byp_y_r;
  logic [63:0]    s4_mag_r;
  fexp_pkg::exp_t s4_ex_r, s4_q_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_byp_r   <= s3_byp_r;
      s4_byp_y_r <= s3_byp_y_r;
      s4_sg_r    <= s3_sg_r;
      s4_mag_r   <= s3_mag_r;
      s4_ex_r    <= s3_ex_r;
      s4_q_r     <= fexp_pkg::norm_exp(s3_mag_r, s3_ex_r);
    end
  end

  // Stage 5: shift to the result lsb.
  logic           s5_byp_r;
  logic [31:0]    s5_byp_y_r;
  fexp_pkg::rnd_t s5_rnd_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_byp_r   <= s4_byp_r;
      s5_byp_y_r <= s4_byp_y_r;
      s5_rnd_r   <= fexp_pkg::shift_to(s4_sg_r, s4_mag_r, s4_ex_r, s4_q_r);
    end
  end

  // Stage 6: round and pack.
  logic [31:0] s6_y_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s6_y_r <= s5_byp_r ? s5_byp_y_r : fexp_pkg::round_pack(s5_rnd_r);
    end
  end

  assign out_vld = vld_r[fexp_pkg::FMA_LAT-1];
  assign out_ctx = ctx_r[fexp_pkg::FMA_LAT-1];
  assign y_bits  = s6_y_r;

endmodule

@@ src/fp32_exp_poly5_top.sv @@
// Top level of the single-precision exponential pipeline: input checks, range
// reduction, degree-5 polynomial and power-of-two scaling. Uses fexp_pkg, fexp_fma.
//
//  channel | direction | beat contents
//  in_     | slave     | tdata[31:0] = x_bits
//  out_    | master    | tdata[31:0] = y_bits
//
// The pipeline is one input stage, eight six-stage multiply-add units,
// two rounding-to-integer stages and four scaling stages.
// One beat enters per cycle while the output side takes beats.
// The whole pipeline advances when the output register is empty or taken, so
// a stall freezes every stage and no beat is lost or repeated.
// Reset (rst_n low, synchronous) clears only the valid bits.
module fp32_exp_poly5_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] y_bits
);

  logic ce;
  assign ce        = out_tready || !out_tvalid;
  assign in_tready = ce;

  // Input stage: catch NaN and out-of-range arguments.
  logic           v0_r;
  fexp_pkg::ctx_t ctx0_nxt, ctx0_r;

  always_comb begin
    ctx0_nxt         = '0;
    ctx0_nxt.x       = in_tdata;
    if (in_tdata[30:0] > fexp_pkg::INF_MAG) begin
      ctx0_nxt.special = 1'b1;
      ctx0_nxt.spec_y  = in_tdata | fexp_pkg::QUIET_BIT;
    end else if (in_tdata[30:0] > fexp_pkg::LIMIT_MAG) begin
      ctx0_nxt.special = 1'b1;
      ctx0_nxt.spec_y  = in_tdata[31] ? fexp_pkg::POS_ZERO : fexp_pkg::POS_INF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx0_r <= ctx0_nxt;
    end
  end

  // x * log2(e); a negative-zero addend makes the unit a plain multiply.
  logic           v_m;
  fexp_pkg::ctx_t ctx_m;
  logic [31:0]    y_m;

  fexp_fma u_mul (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v0_r), .in_ctx(ctx0_r),
    .a_bits(ctx0_r.x), .b_bits(fexp_pkg::K_L2E), .c_bits(fexp_pkg::NEG_ZERO),
    .out_vld(v_m), .out_ctx(ctx_m), .y_bits(y_m)
  );

  // Round to integer, ties to even. Products stay below 2^9 in magnitude.
  logic           r1_v_r, r1_sg_r;
  fexp_pkg::ctx_t r1_ctx_r;
  logic [24:0]    r1_qv_nxt, r1_qv_r;
  logic [4:0]     r_sh;
  logic [47:0]    r_big;

  always_comb begin
    r_sh      = 5'(8'd150 - y_m[30:23]);
    r_big     = {1'b1, y_m[22:0], 24'b0} >> r_sh;
    r1_qv_nxt = '0;
    if (y_m[30:23] >= 8'd126 && y_m[30:23] < 8'd150) begin
      r1_qv_nxt = {1'b0, r_big[47:24]} +
                  {24'b0, r_big[23] & ((|r_big[22:0]) | r_big[24])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
    end else if (ce) begin
      r1_v_r <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r1_ctx_r <= ctx_m;
      r1_sg_r  <= y_m[31];
      r1_qv_r  <= r1_qv_nxt;
    end
  end

  // Convert the integer back to binary32 and keep its signed value for scaling.
  logic           r2_v_r;
  fexp_pkg::ctx_t r2_ctx_nxt, r2_ctx_r;
  logic [6:0]     r_n;
  logic [24:0]    r_norm;

  always_comb begin
    r_n        = fexp_pkg::bit_len64({39'b0, r1_qv_r});
    r_norm     = r1_qv_r << (7'd25 - r_n);
    r2_ctx_nxt = r1_ctx_r;
    if (r1_qv_r == 25'd0) begin
      r2_ctx_nxt.k = {r1_sg_r, 31'b0};
    end else begin
      r2_ctx_nxt.k = {r1_sg_r, 8'(r_n + 7'd126), r_norm[23:1]};
    end
    r2_ctx_nxt.kint = r1_sg_r ? -$signed(11'(r1_qv_r)) : $signed(11'(r1_qv_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_v_r <= 1'b0;
    end else if (ce) begin
      r2_v_r <= r1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r2_ctx_r <= r2_ctx_nxt;
    end
  end

  // Two-constant reduction: r = x - k*ln2.
  logic           v_a, v_b;
  fexp_pkg::ctx_t ctx_a, ctx_b, ctx_br;
  logic [31:0]    y_a, y_b;

  fexp_fma u_red_hi (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(r2_v_r), .in_ctx(r2_ctx_r),
    .a_bits(r2_ctx_r.k), .b_bits(fexp_pkg::K_NLN2_HI), .c_bits(r2_ctx_r.x),
    .out_vld(v_a), .out_ctx(ctx_a), .y_bits(y_a)
  );

  fexp_fma u_red_lo (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v_a), .in_ctx(ctx_a),
    .a_bits(ctx_a.k), .b_bits(fexp_pkg::K_NLN2_LO), .c_bits(y_a),
    .out_vld(v_b), .out_ctx(ctx_b), .y_bits(y_b)
  );

  always_comb begin
    ctx_br   = ctx_b;
    ctx_br.r = y_b;
  end

  // Horner chain of the degree-5 polynomial.
  logic           v_p5, v_p4, v_p3, v_p2, v_p1;
  fexp_pkg::ctx_t ctx_p5, ctx_p4, ctx_p3, ctx_p2, ctx_p1;
  logic [31:0]    y_p5, y_p4, y_p3, y_p2, y_p1;

  fexp_fma u_poly5 (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v_b), .in_ctx(ctx_br),
    .a_bits(fexp_pkg::K_P5), .b_bits(ctx_br.r), .c_bits(fexp_pkg::K_P4),
    .out_vld(v_p5), .out_ctx(ctx_p5), .y_bits(y_p5)
  );

  fexp_fma u_poly4 (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v_p5), .in_ctx(ctx_p5),
    .a_bits(y_p5), .b_bits(ctx_p5.r), .c_bits(fexp_pkg::K_P3),
    .out_vld(v_p4), .out_ctx(ctx_p4), .y_bits(y_p4)
  );

  fexp_fma u_poly3 (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v_p4), .in_ctx(ctx_p4),
    .a_bits(y_p4), .b_bits(ctx_p4.r), .c_bits(fexp_pkg::K_P2),
    .out_vld(v_p3), .out_ctx(ctx_p3), .y_bits(y_p3)
  );

  fexp_fma u_poly2 (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v_p3), .in_ctx(ctx_p3),
    .a_bits(y_p3), .b_bits(ctx_p3.r), .c_bits(fexp_pkg::K_ONE),
    .out_vld(v_p2), .out_ctx(ctx_p2), .y_bits(y_p2)
  );

  fexp_fma u_poly1 (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(v_p2), .in_ctx(ctx_p2),
    .a_bits(y_p2), .b_bits(ctx_p2.r), .c_bits(fexp_pkg::K_ONE),
    .out_vld(v_p1), .out_ctx(ctx_p1), .y_bits(y_p1)
  );

  // Scale stage 1: unpack the polynomial value and add k to its exponent.
  logic           c1_v_r, c1_byp_r, c1_sg_r;
  logic           c1_special_r;
  logic [31:0]    c1_spec_y_r, c1_byp_y_r;
  logic [63:0]    c1_mag_r;
  fexp_pkg::exp_t c1_ex_r;
  fexp_pkg::unp_t up;

  always_comb begin
    up = fexp_pkg::unpack(y_p1);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c1_special_r <= ctx_p1.special;
      c1_spec_y_r  <= ctx_p1.spec_y;
      c1_byp_r     <= (up.m == 24'd0);
      c1_byp_y_r   <= y_p1;
      c1_sg_r      <= up.sg;
      c1_mag_r     <= {40'b0, up.m};
      c1_ex_r      <= up.e + fexp_pkg::exp_t'(ctx_p1.kint);
    end
  end

  // Scale stage 2: result lsb exponent.
  logic           c2_v_r, c2_byp_r, c2_sg_r, c2_special_r;
  logic [31:0]    c2_spec_y_r, c2_byp_y_r;
  logic [63:0]    c2_mag_r;
  fexp_pkg::exp_t c2_ex_r, c2_q_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      c2_special_r <= c1_special_r;
      c2_spec_y_r  <= c1_spec_y_r;
      c2_byp_r     <= c1_byp_r;
      c2_byp_y_r   <= c1_byp_y_r;
      c2_sg_r      <= c1_sg_r;
      c2_mag_r     <= c1_mag_r;
      c2_ex_r      <= c1_ex_r;
      c2_q_r       <= fexp_pkg::norm_exp(c1_mag_r, c1_ex_r);
    end
  end

  // Scale stage 3: shift, with gradual underflow.
  logic           c3_v_r, c3_byp_r, c3_special_r;
  logic [31:0]    c3_spec_y_r, c3_byp_y_r;
  fexp_pkg::rnd_t c3_rnd_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      c3_special_r <= c2_special_r;
      c3_spec_y_r  <= c2_spec_y_r;
      c3_byp_r     <= c2_byp_r;
      c3_byp_y_r   <= c2_byp_y_r;
      c3_rnd_r     <= fexp_pkg::shift_to(c2_sg_r, c2_mag_r, c2_ex_r, c2_q_r);
    end
  end

  // Output register: round, pack, and select special results.
  logic        out_v_r;
  logic [31:0] out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      c3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (ce) begin
      c1_v_r  <= v_p1;
      c2_v_r  <= c1_v_r;
      c3_v_r  <= c2_v_r;
      out_v_r <= c3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (c3_special_r) begin
        out_y_r <= c3_spec_y_r;
      end else if (c3_byp_r) begin
        out_y_r <= c3_byp_y_r;
      end else begin
        out_y_r <= fexp_pkg::round_pack(c3_rnd_r);
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_y_r;

endmodule
